// ===== src/bpcwr_pkg.sv =====
package bpcwr_pkg;

  // Block layout: data bytes, then 4 vertical-parity bytes, then 4 horizontal-parity bytes.
  localparam int DATA_BYTES   = 128;
  localparam int PARITY_BYTES = 4;
  localparam int BLOCK_BYTES  = DATA_BYTES + 2 * PARITY_BYTES;
  localparam int POS_W        = $clog2(BLOCK_BYTES);
  localparam int WORD_W       = 32;
  localparam int COUNT_W      = 16;

  // Packed payload width of the result request (rounded up to whole bytes).
  localparam int RES_BITS     = WORD_W + 2 + COUNT_W + 1;
  localparam int OUT_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic               is_status;
    logic [WORD_W-1:0]  data_word;
    logic               vertical_mismatch;
    logic               horizontal_mismatch;
    logic [COUNT_W-1:0] mismatch_total;
    logic               error_seen;
  } result_t;

endpackage

// ===== src/bpcwr_in_stage.sv =====
module bpcwr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       advance,
  output logic       in_vld,
  output logic [7:0] in_byte
);

  logic       vld;
  logic [7:0] held;

  assign s_tready = !vld || advance;
  assign in_vld   = vld;
  assign in_byte  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      vld <= 1'b1;
    end else if (advance) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held <= s_tdata;
    end
  end

endmodule

// ===== src/bpcwr_engine.sv =====
module bpcwr_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [7:0]         in_byte,
  input  logic               out_can_load,
  output logic               advance,
  output logic               res_load,
  output bpcwr_pkg::result_t res
);

  logic [bpcwr_pkg::POS_W-1:0]   pos, pos_next;
  logic [23:0]                   partial, partial_next;
  logic                          wpar, wpar_next;
  logic [bpcwr_pkg::WORD_W-1:0]  col_xor, col_xor_next;
  logic [bpcwr_pkg::WORD_W-1:0]  row_bits, row_bits_next;
  logic                          col_bad, col_bad_next;
  logic [bpcwr_pkg::COUNT_W-1:0] count, count_next;
  logic                          sticky, sticky_next;

  logic                          in_data, in_vert, last_vert, last_byte, emit;
  logic [1:0]                    lane;
  logic                          par;
  logic [bpcwr_pkg::WORD_W-1:0]  word, placed;
  logic                          hbad;
  logic [bpcwr_pkg::COUNT_W:0]   sum;

  assign lane      = pos[1:0];
  assign in_data   = pos < bpcwr_pkg::POS_W'(bpcwr_pkg::DATA_BYTES);
  assign in_vert   = !in_data &&
                     pos < bpcwr_pkg::POS_W'(bpcwr_pkg::DATA_BYTES + bpcwr_pkg::PARITY_BYTES);
  assign last_vert = pos == bpcwr_pkg::POS_W'(bpcwr_pkg::DATA_BYTES + bpcwr_pkg::PARITY_BYTES - 1);
  assign last_byte = pos == bpcwr_pkg::POS_W'(bpcwr_pkg::BLOCK_BYTES - 1);
  assign emit      = (in_data && lane == 2'd3) || last_byte;

  // Items with no result move on even while the output side is stalled.
  assign advance   = in_vld && (!emit || out_can_load);
  assign res_load  = advance && emit;

  assign par    = wpar ^ (^in_byte);
  assign word   = {partial, in_byte};
  // Parity bytes arrive MSB first: lane 0 lands in bits 31..24.
  assign placed = {in_byte, 24'd0} >> {lane, 3'd0};

  always_comb begin
    pos_next      = pos + 1'b1;
    partial_next  = partial;
    wpar_next     = wpar;
    col_xor_next  = col_xor;
    row_bits_next = row_bits;
    col_bad_next  = col_bad;
    count_next    = count;
    sticky_next   = sticky;
    hbad          = 1'b0;
    sum           = '0;
    res           = '0;

    if (in_data) begin
      if (lane != 2'd3) begin
        partial_next = {partial[15:0], in_byte};
        wpar_next    = par;
      end else begin
        col_xor_next = col_xor ^ word;
        // word w sets bit 31 - w
        row_bits_next[~pos[6:2]] = row_bits[~pos[6:2]] | par;
        partial_next = '0;
        wpar_next    = 1'b0;
      end
      res.data_word      = word;
      res.mismatch_total = count;
      res.error_seen     = sticky;
    end else if (in_vert) begin
      col_xor_next = col_xor ^ placed;
      if (last_vert) begin
        col_bad_next = |col_xor_next;
      end
    end else begin
      row_bits_next = row_bits ^ placed;
      if (last_byte) begin
        hbad = |row_bits_next;
        sum  = {1'b0, count} + {{bpcwr_pkg::COUNT_W{1'b0}}, col_bad}
                             + {{bpcwr_pkg::COUNT_W{1'b0}}, hbad};
        count_next    = sum[bpcwr_pkg::COUNT_W] ? bpcwr_pkg::COUNT_MAX
                                                : sum[bpcwr_pkg::COUNT_W-1:0];
        sticky_next   = sticky | col_bad | hbad;
        pos_next      = '0;
        partial_next  = '0;
        wpar_next     = 1'b0;
        col_xor_next  = '0;
        row_bits_next = '0;
        col_bad_next  = 1'b0;
      end
      res.is_status           = 1'b1;
      res.vertical_mismatch   = col_bad;
      res.horizontal_mismatch = hbad;
      res.mismatch_total      = count_next;
      res.error_seen          = sticky_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      partial  <= '0;
      wpar     <= 1'b0;
      col_xor  <= '0;
      row_bits <= '0;
      col_bad  <= 1'b0;
      count    <= '0;
      sticky   <= 1'b0;
    end else if (advance) begin
      pos      <= pos_next;
      partial  <= partial_next;
      wpar     <= wpar_next;
      col_xor  <= col_xor_next;
      row_bits <= row_bits_next;
      col_bad  <= col_bad_next;
      count    <= count_next;
      sticky   <= sticky_next;
    end
  end

endmodule

// ===== src/bpcwr_out_stage.sv =====
module bpcwr_out_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                res_load,
  input  bpcwr_pkg::result_t                  res,
  output logic                                out_can_load,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bpcwr_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                m_tuser
);

  logic               vld;
  bpcwr_pkg::result_t held;

  assign out_can_load = !vld || m_tready;
  assign m_tvalid     = vld;
  assign m_tuser      = held.is_status;
  assign m_tdata      = {{(bpcwr_pkg::OUT_TDATA_W - bpcwr_pkg::RES_BITS){1'b0}},
                         held.error_seen, held.mismatch_total,
                         held.horizontal_mismatch, held.vertical_mismatch,
                         held.data_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (res_load) begin
      vld <= 1'b1;
    end else if (m_tready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      held <= res;
    end
  end

endmodule

// ===== src/block_parity_checked_word_reader_core.sv =====
// Two-dimensional block parity checker. The input is a byte stream cut into
// 136-byte blocks: 128 data bytes, 4 vertical-parity bytes (XOR of the 32 data
// words, MSB first) and 4 horizontal-parity bytes (bit 31-w is the parity of
// word w, MSB first). Every fourth data byte yields a data request with the
// big-endian word; the last parity byte yields a status request with both
// mismatch flags, a saturating 16-bit mismatch count (a block failing both
// checks adds two) and a sticky error flag. Throughput is one byte per clock
// with no gaps while the output register can take each result; a byte passes
// an input register and then the state update, whose result lands in the
// output register that drives m_tvalid. Bytes that produce no result keep
// flowing while the output register holds a stalled request.
module block_parity_checked_word_reader_core (
  input  logic                              clk,
  input  logic                              rst,
  // stream_byte[7:0]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,
  // data_word[31:0], vertical_mismatch[32], horizontal_mismatch[33],
  // mismatch_total[49:34], error_seen[50], zero fill above
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bpcwr_pkg::OUT_TDATA_W-1:0] m_tdata,
  // is_status[0]
  output logic                              m_tuser
);

  logic               in_vld;
  logic [7:0]         in_byte;
  logic               advance;
  logic               res_load;
  logic               out_can_load;
  bpcwr_pkg::result_t res;

  bpcwr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .in_vld   (in_vld),
    .in_byte  (in_byte)
  );

  // Per-block parity state, word assembly and mismatch accounting.
  bpcwr_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (in_vld),
    .in_byte      (in_byte),
    .out_can_load (out_can_load),
    .advance      (advance),
    .res_load     (res_load),
    .res          (res)
  );

  bpcwr_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res          (res),
    .out_can_load (out_can_load),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

endmodule
